// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/rfs_pkg.sv -----
// ----------------------------------------------------------------------------
// rfs_pkg
// Types and constants of the resonance frequency sweep.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int CLOCK_BITS     = 30;
    localparam int PERIOD_BITS    = 30;
    localparam int COMPARE_BITS   = 29;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int DIV_STEPS      = CLOCK_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    localparam logic [CLOCK_BITS-1:0] DEFAULT_CLOCK  = 30'd72000000;
    localparam int unsigned           DEFAULT_START  = 125000;
    localparam int unsigned           DEFAULT_END    = 130000;
    localparam int unsigned           DEFAULT_STEP   = 500;
    localparam int unsigned           DEFAULT_WINDOW = 1024;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SYS_CLOCK  = 3'd0,
        REG_START_FREQ = 3'd1,
        REG_END_FREQ   = 3'd2,
        REG_STEP_FREQ  = 3'd3,
        REG_WINDOW     = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_SAMPLE = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

endpackage

// ----- sv/rfs_ifs.sv -----
// ----------------------------------------------------------------------------
// rfs channel interfaces
// Request, result and configuration channels of the frequency sweep.
// ----------------------------------------------------------------------------
interface rfs_request_if #(parameter int SAMPLE_BITS = 12) ();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface rfs_result_if import rfs_pkg::*; #(parameter int FREQ_BITS = 24) ();
    logic                    valid;
    logic                    ready;
    logic                    pwm_enable;
    logic [FREQ_BITS-1:0]    point_freq;
    logic [PERIOD_BITS-1:0]  pwm_period;
    logic [COMPARE_BITS-1:0] pwm_compare;
    logic [FREQ_BITS-1:0]    peak_freq;
    logic                    sweep_done;

    modport source (output valid, output pwm_enable, output point_freq, output pwm_period,
                    output pwm_compare, output peak_freq, output sweep_done, input ready);
    modport sink   (input valid, input pwm_enable, input point_freq, input pwm_period,
                    input pwm_compare, input peak_freq, input sweep_done, output ready);
endinterface

interface rfs_cfg_if import rfs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/resonance_frequency_sweep.sv -----
// ----------------------------------------------------------------------------
// resonance_frequency_sweep
// Steps a drive frequency over a range, sums current samples per point and
// keeps the frequency with the largest sum.
// ----------------------------------------------------------------------------
// A start request (kind 0) begins a sweep and a sample request (kind 1) adds
// one converter sample. Samples that do not close a window are taken at one
// per cycle. A start with start <= end, or a sample that closes a window and
// moves to a new point, computes the timer period with a restoring divider
// that retires one quotient bit per cycle, so such a request passes through
// accept, 30 divide steps and result load before the next request is taken.
// A request that ends the sweep skips the divider. The result sits in an
// output register, so the next request is accepted while it waits.
`include "assert_macros.svh"

module resonance_frequency_sweep
    import rfs_pkg::*;
#(
    parameter int COUNT_BITS  = 16,
    parameter int SAMPLE_BITS = 12,
    parameter int FREQ_BITS   = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rfs_cfg_if.sink              cfg,
    rfs_request_if.sink          requests,
    rfs_result_if.source         results
);

    localparam int SUM_BITS = COUNT_BITS + SAMPLE_BITS;

    state_t                  state_reg, state_next;

    logic [CLOCK_BITS-1:0]   sys_clock_reg, sys_clock_next;
    logic [FREQ_BITS-1:0]    start_freq_reg, start_freq_next;
    logic [FREQ_BITS-1:0]    end_freq_reg, end_freq_next;
    logic [FREQ_BITS-1:0]    step_freq_reg, step_freq_next;
    logic [COUNT_BITS-1:0]   window_reg, window_next;

    logic                    sweeping_reg, sweeping_next;
    logic [FREQ_BITS:0]      current_freq_reg, current_freq_next;
    logic [SUM_BITS-1:0]     sample_sum_reg, sample_sum_next;
    logic [COUNT_BITS-1:0]   sample_count_reg, sample_count_next;
    logic [SUM_BITS-1:0]     max_sum_reg, max_sum_next;
    logic [FREQ_BITS-1:0]    peak_freq_reg, peak_freq_next;
    logic                    run_reg, run_next;

    logic [FREQ_BITS-1:0]    rem_reg, rem_next;
    logic [CLOCK_BITS-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_enable_reg, out_enable_next;
    logic [FREQ_BITS-1:0]    out_freq_reg, out_freq_next;
    logic [PERIOD_BITS-1:0]  out_period_reg, out_period_next;
    logic [COMPARE_BITS-1:0] out_compare_reg, out_compare_next;
    logic [FREQ_BITS-1:0]    out_best_reg, out_best_next;
    logic                    out_done_reg, out_done_next;

    logic                    in_fire;
    logic                    out_fire;
    logic [SUM_BITS-1:0]     sum_add;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [FREQ_BITS:0]      freq_step;
    logic [FREQ_BITS:0]      trial;
    logic [FREQ_BITS-1:0]    divisor;
    logic                    quo_bit;

    assign cfg.ready           = 1'b1;
    assign requests.ready      = (state_reg == ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.pwm_enable  = out_enable_reg;
    assign results.point_freq  = out_freq_reg;
    assign results.pwm_period  = out_period_reg;
    assign results.pwm_compare = out_compare_reg;
    assign results.peak_freq   = out_best_reg;
    assign results.sweep_done  = out_done_reg;

    assign in_fire   = requests.valid && requests.ready;
    assign out_fire  = results.valid && results.ready;
    assign sum_add   = sample_sum_reg + SUM_BITS'(requests.sample);
    assign count_inc = sample_count_reg + COUNT_BITS'(1);
    assign freq_step = current_freq_reg + {1'b0, step_freq_reg};
    assign divisor   = current_freq_reg[FREQ_BITS-1:0];
    assign trial     = {rem_reg, quo_reg[CLOCK_BITS-1]};
    assign quo_bit   = (trial >= {1'b0, divisor});

    always_comb
    begin
        state_next        = state_reg;
        sys_clock_next    = sys_clock_reg;
        start_freq_next   = start_freq_reg;
        end_freq_next     = end_freq_reg;
        step_freq_next    = step_freq_reg;
        window_next       = window_reg;
        sweeping_next     = sweeping_reg;
        current_freq_next = current_freq_reg;
        sample_sum_next   = sample_sum_reg;
        sample_count_next = sample_count_reg;
        max_sum_next      = max_sum_reg;
        peak_freq_next    = peak_freq_reg;
        run_next          = run_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        out_enable_next   = out_enable_reg;
        out_freq_next     = out_freq_reg;
        out_period_next   = out_period_reg;
        out_compare_next  = out_compare_reg;
        out_best_next     = out_best_reg;
        out_done_next     = out_done_reg;

        if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SYS_CLOCK:  sys_clock_next  = cfg.data[CLOCK_BITS-1:0];
                REG_START_FREQ: start_freq_next = cfg.data[FREQ_BITS-1:0];
                REG_END_FREQ:   end_freq_next   = cfg.data[FREQ_BITS-1:0];
                REG_STEP_FREQ:  step_freq_next  = cfg.data[FREQ_BITS-1:0];
                REG_WINDOW:     window_next     = cfg.data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rem_next     = '0;
                    quo_next     = sys_clock_reg;
                    div_cnt_next = '0;
                    if (item_kind_t'(requests.kind) == KIND_START)
                    begin
                        sample_sum_next   = '0;
                        sample_count_next = '0;
                        max_sum_next      = '0;
                        current_freq_next = {1'b0, start_freq_reg};
                        if (start_freq_reg > end_freq_reg)
                        begin
                            sweeping_next = 1'b0;
                            run_next      = 1'b0;
                            state_next    = ST_LOAD;
                        end
                        else
                        begin
                            sweeping_next = 1'b1;
                            run_next      = 1'b1;
                            state_next    = ST_DIVIDE;
                        end
                    end
                    else if (sweeping_reg)
                    begin
                        if (count_inc < window_reg)
                        begin
                            sample_sum_next   = sum_add;
                            sample_count_next = count_inc;
                        end
                        else
                        begin
                            if (sum_add > max_sum_reg)
                            begin
                                max_sum_next   = sum_add;
                                peak_freq_next = current_freq_reg[FREQ_BITS-1:0];
                            end
                            sample_sum_next   = '0;
                            sample_count_next = '0;
                            current_freq_next = freq_step;
                            if (freq_step <= {1'b0, end_freq_reg})
                            begin
                                run_next   = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                            else
                            begin
                                sweeping_next = 1'b0;
                                run_next      = 1'b0;
                                state_next    = ST_LOAD;
                            end
                        end
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (quo_bit)
                begin
                    rem_next = trial[FREQ_BITS-1:0] - divisor;
                end
                else
                begin
                    rem_next = trial[FREQ_BITS-1:0];
                end
                quo_next     = {quo_reg[CLOCK_BITS-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + DIV_CNT_BITS'(1);
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = peak_freq_reg;
                    if (run_reg)
                    begin
                        out_enable_next  = 1'b1;
                        out_done_next    = 1'b0;
                        out_freq_next    = divisor;
                        out_compare_next = quo_reg[CLOCK_BITS-1:1];
                        if (divisor == '0)
                        begin
                            out_period_next = '1;
                        end
                        else
                        begin
                            out_period_next = quo_reg - PERIOD_BITS'(1);
                        end
                    end
                    else
                    begin
                        out_enable_next  = 1'b0;
                        out_done_next    = 1'b1;
                        out_freq_next    = '0;
                        out_period_next  = '0;
                        out_compare_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sys_clock_reg    <= DEFAULT_CLOCK;
            start_freq_reg   <= FREQ_BITS'(DEFAULT_START);
            end_freq_reg     <= FREQ_BITS'(DEFAULT_END);
            step_freq_reg    <= FREQ_BITS'(DEFAULT_STEP);
            window_reg       <= COUNT_BITS'(DEFAULT_WINDOW);
            sweeping_reg     <= 1'b0;
            current_freq_reg <= '0;
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            max_sum_reg      <= '0;
            peak_freq_reg    <= FREQ_BITS'(DEFAULT_START);
            run_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sys_clock_reg    <= sys_clock_next;
            start_freq_reg   <= start_freq_next;
            end_freq_reg     <= end_freq_next;
            step_freq_reg    <= step_freq_next;
            window_reg       <= window_next;
            sweeping_reg     <= sweeping_next;
            current_freq_reg <= current_freq_next;
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
            max_sum_reg      <= max_sum_next;
            peak_freq_reg    <= peak_freq_next;
            run_reg          <= run_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        div_cnt_reg     <= div_cnt_next;
        out_enable_reg  <= out_enable_next;
        out_freq_reg    <= out_freq_next;
        out_period_reg  <= out_period_next;
        out_compare_reg <= out_compare_next;
        out_best_reg    <= out_best_next;
        out_done_reg    <= out_done_next;
    end

    `ASSERT_SAME(a_done_fields_clear, clk, rst_n, out_valid_reg && out_done_reg, !out_enable_reg && out_freq_reg == '0 && out_period_reg == '0)
    `ASSERT_NEXT(a_idle_sample_no_work, clk, rst_n, in_fire && requests.kind && !sweeping_reg, state_reg == ST_IDLE && !sweeping_reg)
    `ASSERT_NEXT(a_load_fills_output, clk, rst_n, state_reg == ST_LOAD && (!out_valid_reg || out_fire), out_valid_reg && state_reg == ST_IDLE)
    `ASSERT_SAME(a_divide_needs_run, clk, rst_n, state_reg == ST_DIVIDE, run_reg && sweeping_reg)

endmodule
